[src/mur_pkg.sv]
// mini uart register block: shared types, register and operation codes, fifo sizing
// no dependencies; imported by every module in src
package mur_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  localparam logic [7:0] DLAB_BIT = 8'h80;
  localparam logic [7:0] MSR_VALUE = 8'h10;
  localparam logic [7:0] CNTL_RESET = 8'h03;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_RX_BYTE  = 2'd2,
    OP_TX_DRAIN = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_IRQ     = 4'd0,
    REG_ENABLES = 4'd1,
    REG_IO      = 4'd2,
    REG_IER     = 4'd3,
    REG_IIR     = 4'd4,
    REG_LCR     = 4'd5,
    REG_MCR     = 4'd6,
    REG_LSR     = 4'd7,
    REG_MSR     = 4'd8,
    REG_SCRATCH = 4'd9,
    REG_CNTL    = 4'd10,
    REG_STAT    = 4'd11,
    REG_BAUD    = 4'd12
  } reg_idx_t;

  typedef enum logic [1:0] {
    ID_NONE     = 2'd0,
    ID_TX_EMPTY = 2'd1,
    ID_RX_DATA  = 2'd2
  } int_id_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] write_data;
    logic [3:0]  reg_index;
    logic [1:0]  operation;
  } req_t;

  typedef struct packed {
    logic        irq;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [31:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_next;
  } fifo_stat_t;

endpackage

[src/mini_uart_register_block.sv]
// mini uart register block top level: request register, core decode, two fifos, result register
// depends on mur_pkg, mur_fifo and mur_core
//
// usage:
//   s_axis carries one request per accepted beat: a register read, a register write,
//   a byte arriving from the receive line, or the transmitter draining one byte.
//   m_axis returns exactly one result per request, in order: read data, the drained
//   byte with its valid flag, and the interrupt line as it stands after the request.
//   requests pass the request register, then the result register; the block takes
//   one request per cycle for as long as results are taken, since each request is
//   decoded by shallow logic between the request register and the result register.
//   when m_axis_tready is low the result register holds, the request register fills,
//   and then s_axis_tready drops until the result is taken; nothing is lost.
//   reset clears both fifos and all registers (cntl to 0x03, msr reads 0x10); the
//   block comes up disabled, with reads returning 0 until enables bit 0 is written.
//   fifo contents are not cleared, only their counts and heads.
module mini_uart_register_block (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation[1:0], reg_index[5:2], write_data[21:6], rx_byte[29:22], zero pad
  input  logic [mur_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data[31:0], tx_valid[32], tx_byte[40:33], irq[41], zero pad
  output logic [mur_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import mur_pkg::*;

  req_t       req;
  logic       req_valid;
  rsp_t       rsp;
  rsp_t       rsp_q;
  logic       rsp_valid;
  logic       advance;
  fifo_ctrl_t rx_ctrl;
  fifo_ctrl_t tx_ctrl;
  fifo_stat_t rx_stat;
  fifo_stat_t tx_stat;
  logic [7:0] rx_data;
  logic [7:0] tx_data;

  assign advance       = req_valid && (!rsp_valid || m_axis_tready);
  assign s_axis_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req <= req_t'(s_axis_tdata[$bits(req_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (m_axis_tready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  mur_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .req     (req),
    .rx_stat (rx_stat),
    .tx_stat (tx_stat),
    .rx_data (rx_data),
    .tx_data (tx_data),
    .rx_ctrl (rx_ctrl),
    .tx_ctrl (tx_ctrl),
    .rsp     (rsp)
  );

  mur_fifo u_rx_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (rx_ctrl),
    .wr_byte (req.rx_byte),
    .rd_byte (rx_data),
    .stat    (rx_stat)
  );

  mur_fifo u_tx_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tx_ctrl),
    .wr_byte (req.write_data[7:0]),
    .rd_byte (tx_data),
    .stat    (tx_stat)
  );

  assign m_axis_tvalid = rsp_valid;
  assign m_axis_tdata  = M_DATA_W'(rsp_q);

endmodule

[src/mur_fifo.sv]
// byte fifo with head pointer and fill count, used for both receive and transmit
// depends on mur_pkg for depth and control/status structs
module mur_fifo (
  input  logic                clk,
  input  logic                rst,
  input  mur_pkg::fifo_ctrl_t ctrl,
  input  logic [7:0]          wr_byte,
  output logic [7:0]          rd_byte,
  output mur_pkg::fifo_stat_t stat
);
  import mur_pkg::*;

  logic [7:0]       store [FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W:0]   wr_sum;
  logic             push_ok;
  logic             pop_ok;

  assign push_ok = ctrl.push && (count != CNT_FULL) && !ctrl.flush;
  assign pop_ok  = ctrl.pop && (count != '0) && !ctrl.flush;

  always_comb begin
    wr_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
    if (wr_sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
      wr_ptr = PTR_W'(wr_sum - (CNT_W+1)'(FIFO_DEPTH));
    end else begin
      wr_ptr = PTR_W'(wr_sum);
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctrl.flush) begin
      head_next  = '0;
      count_next = '0;
    end else begin
      if (pop_ok) begin
        head_next = (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count_next = count + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= wr_byte;
    end
  end

  assign rd_byte         = store[head];
  assign stat.count      = count;
  assign stat.count_next = count_next;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL) else $error("fifo count above depth");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush |=> (count == '0) && (head == '0)) else $error("flush left data");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.push && !ctrl.pop && !ctrl.flush && count != CNT_FULL)
      |=> count == $past(count) + 1'b1) else $error("push lost");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (ctrl.pop && !ctrl.push && !ctrl.flush && count == '0)
      |=> $stable(head) && count == '0) else $error("pop on empty moved head");

endmodule

[src/mur_core.sv]
// register file and access decode: enables, ier, lcr, mcr, scratch, cntl, baud, overrun
// depends on mur_pkg; drives the two mur_fifo instances through control structs
module mur_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  mur_pkg::req_t       req,
  input  mur_pkg::fifo_stat_t rx_stat,
  input  mur_pkg::fifo_stat_t tx_stat,
  input  logic [7:0]          rx_data,
  input  logic [7:0]          tx_data,
  output mur_pkg::fifo_ctrl_t rx_ctrl,
  output mur_pkg::fifo_ctrl_t tx_ctrl,
  output mur_pkg::rsp_t       rsp
);
  import mur_pkg::*;

  logic [7:0]  enable_bits, enable_bits_next;
  logic [7:0]  int_enable, int_enable_next;
  logic [7:0]  line_control, line_control_next;
  logic [7:0]  modem_control, modem_control_next;
  logic [7:0]  scratch_byte, scratch_byte_next;
  logic [7:0]  extra_control, extra_control_next;
  logic [15:0] baud_divisor, baud_divisor_next;
  logic        overrun_flag, overrun_flag_next;

  fifo_ctrl_t  rx_op;
  fifo_ctrl_t  tx_op;
  logic [7:0]  lo;
  logic        en;
  logic        dlab;
  int_id_t     id;
  logic [31:0] rd;
  logic        tv;
  logic [7:0]  tb;
  logic        irq_next;

  function automatic int_id_t calc_id(input logic [7:0] ier, input logic [CNT_W-1:0] rxc,
                                      input logic [CNT_W-1:0] txc);
    int_id_t r;
    if (ier[1] && txc == '0) begin
      r = ID_TX_EMPTY;
    end else if (ier[0] && rxc != '0) begin
      r = ID_RX_DATA;
    end else begin
      r = ID_NONE;
    end
    return r;
  endfunction

  assign lo   = req.write_data[7:0];
  assign en   = enable_bits[0];
  assign dlab = (line_control & DLAB_BIT) != 8'h00;
  assign id   = calc_id(int_enable, rx_stat.count, tx_stat.count);

  always_comb begin
    enable_bits_next   = enable_bits;
    int_enable_next    = int_enable;
    line_control_next  = line_control;
    modem_control_next = modem_control;
    scratch_byte_next  = scratch_byte;
    extra_control_next = extra_control;
    baud_divisor_next  = baud_divisor;
    overrun_flag_next  = overrun_flag;
    rx_op = '0;
    tx_op = '0;
    rd    = '0;
    tv    = 1'b0;
    tb    = '0;
    case (req.operation)
      OP_READ: begin
        if (en) begin
          case (req.reg_index)
            REG_IRQ:     rd = 32'(id != ID_NONE);
            REG_ENABLES: rd = 32'(enable_bits);
            REG_IO: begin
              if (dlab) begin
                line_control_next = line_control & ~DLAB_BIT;
                rd = 32'(baud_divisor[7:0]);
              end else if (rx_stat.count != '0) begin
                rx_op.pop = 1'b1;
                rd = 32'(rx_data);
              end
            end
            REG_IER:     rd = dlab ? 32'(baud_divisor[15:8]) : 32'(int_enable);
            REG_IIR:     rd = {24'h0, 2'b11, 3'b000, id, id == ID_NONE};
            REG_LCR:     rd = 32'(line_control);
            REG_MCR:     rd = 32'(modem_control);
            REG_LSR: begin
              rd = {25'h0, tx_stat.count == '0, tx_stat.count != CNT_FULL, 3'b000,
                    overrun_flag, rx_stat.count != '0};
              overrun_flag_next = 1'b0;
            end
            REG_MSR:     rd = 32'(MSR_VALUE);
            REG_SCRATCH: rd = 32'(scratch_byte);
            REG_CNTL:    rd = 32'(extra_control);
            REG_STAT: begin
              rd = {8'(tx_stat.count), 8'(rx_stat.count), 6'h00,
                    (rx_stat.count == '0) && (tx_stat.count == '0),
                    tx_stat.count == '0, 2'b00,
                    tx_stat.count == CNT_FULL, overrun_flag,
                    tx_stat.count == '0, rx_stat.count == '0,
                    tx_stat.count != CNT_FULL, rx_stat.count != '0};
            end
            REG_BAUD:    rd = 32'(baud_divisor);
            default:     rd = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (!en) begin
          if (req.reg_index == REG_ENABLES) begin
            enable_bits_next = lo;
          end
        end else begin
          case (req.reg_index)
            REG_ENABLES: enable_bits_next = lo;
            REG_IO: begin
              if (dlab) begin
                line_control_next = line_control & ~DLAB_BIT;
                baud_divisor_next = {baud_divisor[15:8], lo};
              end else begin
                tx_op.push = 1'b1;
              end
            end
            REG_IER: begin
              if (dlab) begin
                baud_divisor_next = {lo, baud_divisor[7:0]};
              end else begin
                int_enable_next = lo;
              end
            end
            REG_IIR: begin
              rx_op.flush = req.write_data[1];
              tx_op.flush = req.write_data[2];
            end
            REG_LCR:     line_control_next = lo;
            REG_MCR:     modem_control_next = lo;
            REG_SCRATCH: scratch_byte_next = lo;
            REG_CNTL:    extra_control_next = lo;
            REG_BAUD:    baud_divisor_next = req.write_data;
            default:     ;
          endcase
        end
      end
      OP_RX_BYTE: begin
        rx_op.push = 1'b1;
        if (rx_stat.count == CNT_FULL) begin
          overrun_flag_next = 1'b1;
        end
      end
      OP_TX_DRAIN: begin
        tx_op.pop = 1'b1;
        if (tx_stat.count != '0) begin
          tv = 1'b1;
          tb = tx_data;
        end
      end
      default: ;
    endcase
  end

  assign rx_ctrl = fire ? rx_op : '0;
  assign tx_ctrl = fire ? tx_op : '0;

  assign irq_next = enable_bits_next[0] &&
    (calc_id(int_enable_next, rx_stat.count_next, tx_stat.count_next) != ID_NONE);

  assign rsp.read_data = rd;
  assign rsp.tx_valid  = tv;
  assign rsp.tx_byte   = tb;
  assign rsp.irq       = irq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bits   <= '0;
      int_enable    <= '0;
      line_control  <= '0;
      modem_control <= '0;
      scratch_byte  <= '0;
      extra_control <= CNTL_RESET;
      baud_divisor  <= '0;
      overrun_flag  <= 1'b0;
    end else if (fire) begin
      enable_bits   <= enable_bits_next;
      int_enable    <= int_enable_next;
      line_control  <= line_control_next;
      modem_control <= modem_control_next;
      scratch_byte  <= scratch_byte_next;
      extra_control <= extra_control_next;
      baud_divisor  <= baud_divisor_next;
      overrun_flag  <= overrun_flag_next;
    end
  end

  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (fire && !en && req.operation == OP_READ) |-> rd == '0 && !rx_ctrl.pop)
    else $error("read while disabled had effect");

  a_io_clears_dlab: assert property (@(posedge clk) disable iff (rst)
    (fire && en && dlab && req.reg_index == REG_IO &&
     (req.operation == OP_READ || req.operation == OP_WRITE)) |=> !dlab)
    else $error("dlab not cleared by io access");

  a_full_rx_overrun: assert property (@(posedge clk) disable iff (rst)
    (fire && req.operation == OP_RX_BYTE && rx_stat.count == CNT_FULL) |=> overrun_flag)
    else $error("overrun not flagged");

endmodule

[verif/tb_mini_uart_register_block.sv]
`timescale 1ns / 100ps
// testbench for mini_uart_register_block: directed and random register, fifo and line traffic
// on the request stream, every response checked in order against a behavioral register model
// depends on mur_pkg and the block rtl in src

module tb_mini_uart_register_block;
  import mur_pkg::*;

  typedef struct {
    req_t req;
    bit   wait_idle;
  } uart_request_t;

  localparam int TAIL_CYCLES = 8;
  localparam logic [3:0] REG_UNMAPPED = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  uart_request_t queued_requests[$];
  rsp_t expected_responses[$];
  bit req_taken = 1'b0;
  bit rsp_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int mismatch_count = 0;

  logic [7:0] rx_mem [FIFO_DEPTH];
  logic [7:0] tx_mem [FIFO_DEPTH];
  int unsigned rx_fill, rx_rd, tx_fill, tx_rd;
  logic [7:0] ctl_enables, ctl_ier, ctl_lcr, ctl_mcr, ctl_msr, ctl_scratch, ctl_cntl;
  logic [15:0] baud_div;
  logic overrun;

  mini_uart_register_block dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  task automatic reset_uart_model();
    rx_fill = 0;
    rx_rd = 0;
    tx_fill = 0;
    tx_rd = 0;
    ctl_enables = 8'h00;
    ctl_ier = 8'h00;
    ctl_lcr = 8'h00;
    ctl_mcr = 8'h00;
    ctl_msr = MSR_VALUE;
    ctl_scratch = 8'h00;
    ctl_cntl = CNTL_RESET;
    baud_div = 16'h0000;
    overrun = 1'b0;
  endtask

  function automatic int_id_t current_int_id();
    if (ctl_ier[1] && tx_fill == 0) return ID_TX_EMPTY;
    if (ctl_ier[0] && rx_fill != 0) return ID_RX_DATA;
    return ID_NONE;
  endfunction

  function automatic logic [31:0] read_register(logic [3:0] idx);
    logic [31:0] v;
    int_id_t id;
    v = '0;
    if (!ctl_enables[0]) return '0;
    case (idx)
      REG_IRQ: v[0] = current_int_id() != ID_NONE;
      REG_ENABLES: v[7:0] = ctl_enables;
      REG_IO: begin
        if (ctl_lcr[7]) begin
          ctl_lcr[7] = 1'b0;
          v[7:0] = baud_div[7:0];
        end else if (rx_fill != 0) begin
          v[7:0] = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % FIFO_DEPTH;
          rx_fill--;
        end
      end
      REG_IER: v[7:0] = ctl_lcr[7] ? baud_div[15:8] : ctl_ier;
      REG_IIR: begin
        id = current_int_id();
        v[7:0] = {2'b11, 3'b000, id, id == ID_NONE};
      end
      REG_LCR: v[7:0] = ctl_lcr;
      REG_MCR: v[7:0] = ctl_mcr;
      REG_LSR: begin
        v[0] = rx_fill != 0;
        v[1] = overrun;
        v[5] = tx_fill < FIFO_DEPTH;
        v[6] = tx_fill == 0;
        overrun = 1'b0;
      end
      REG_MSR: v[7:0] = ctl_msr;
      REG_SCRATCH: v[7:0] = ctl_scratch;
      REG_CNTL: v[7:0] = ctl_cntl;
      REG_STAT: begin
        v[0] = rx_fill != 0;
        v[1] = tx_fill < FIFO_DEPTH;
        v[2] = rx_fill == 0;
        v[3] = tx_fill == 0;
        v[4] = overrun;
        v[5] = tx_fill >= FIFO_DEPTH;
        v[8] = tx_fill == 0;
        v[9] = rx_fill == 0 && tx_fill == 0;
        v[23:16] = 8'((rx_fill < FIFO_DEPTH) ? rx_fill : FIFO_DEPTH);
        v[31:24] = 8'((tx_fill < FIFO_DEPTH) ? tx_fill : FIFO_DEPTH);
      end
      REG_BAUD: v[15:0] = baud_div;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic void write_register(logic [3:0] idx, logic [15:0] wd);
    logic [7:0] lo;
    lo = wd[7:0];
    if (!ctl_enables[0]) begin
      if (idx == REG_ENABLES) ctl_enables = lo;
      return;
    end
    case (idx)
      REG_ENABLES: ctl_enables = lo;
      REG_IO: begin
        if (ctl_lcr[7]) begin
          ctl_lcr[7] = 1'b0;
          baud_div[7:0] = lo;
        end else if (tx_fill < FIFO_DEPTH) begin
          tx_mem[(tx_rd + tx_fill) % FIFO_DEPTH] = lo;
          tx_fill++;
        end
      end
      REG_IER: begin
        if (ctl_lcr[7]) baud_div[15:8] = lo;
        else ctl_ier = lo;
      end
      REG_IIR: begin
        if (wd[1]) begin
          rx_fill = 0;
          rx_rd = 0;
        end
        if (wd[2]) begin
          tx_fill = 0;
          tx_rd = 0;
        end
      end
      REG_LCR: ctl_lcr = lo;
      REG_MCR: ctl_mcr = lo;
      REG_SCRATCH: ctl_scratch = lo;
      REG_CNTL: ctl_cntl = lo;
      REG_BAUD: baud_div = wd;
      default: ;
    endcase
  endfunction

  function automatic rsp_t predict_uart_response(req_t r);
    rsp_t rsp;
    rsp = '0;
    case (r.operation)
      OP_READ: rsp.read_data = read_register(r.reg_index);
      OP_WRITE: write_register(r.reg_index, r.write_data);
      OP_RX_BYTE: begin
        if (rx_fill < FIFO_DEPTH) begin
          rx_mem[(rx_rd + rx_fill) % FIFO_DEPTH] = r.rx_byte;
          rx_fill++;
        end else begin
          overrun = 1'b1;
        end
      end
      default: begin
        if (tx_fill != 0) begin
          rsp.tx_valid = 1'b1;
          rsp.tx_byte = tx_mem[tx_rd];
          tx_rd = (tx_rd + 1) % FIFO_DEPTH;
          tx_fill--;
        end
      end
    endcase
    rsp.irq = ctl_enables[0] && current_int_id() != ID_NONE;
    return rsp;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  task automatic add_request(logic [1:0] op, logic [3:0] idx, logic [15:0] wd = '0,
                             logic [7:0] rxb = '0);
    uart_request_t item;
    item.req.operation = op;
    item.req.reg_index = idx;
    item.req.write_data = wd;
    item.req.rx_byte = rxb;
    item.wait_idle = 1'b0;
    queued_requests.push_back(item);
  endtask

  task automatic add_random_sequence();
    logic [1:0] op;
    logic [3:0] idx;
    logic [15:0] wd;
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        op = 2'($urandom_range(0, 3));
        idx = 4'($urandom_range(0, 15));
        wd = 16'($urandom);
        if (op == OP_WRITE && idx == REG_ENABLES && $urandom_range(0, 9) != 0) wd[0] = 1'b1;
        add_request(op, idx, wd, 8'($urandom));
      end
      2: begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          add_request(OP_WRITE, REG_IO, 16'($urandom));
          if ($urandom_range(0, 3) == 0) add_request(OP_READ, REG_STAT);
        end
        n = $urandom_range(1, 10);
        repeat (n) add_request(OP_TX_DRAIN, 4'($urandom_range(0, 15)), 16'($urandom));
      end
      3: begin
        n = $urandom_range(1, 10);
        repeat (n) add_request(OP_RX_BYTE, 4'($urandom_range(0, 15)), 16'($urandom),
                               8'($urandom));
        n = $urandom_range(1, 10);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0, 1: add_request(OP_READ, REG_IO);
            2: add_request(OP_READ, REG_LSR);
            3: add_request(OP_READ, REG_STAT);
            default: add_request(OP_READ, $urandom_range(0, 1) ? REG_IIR : REG_IRQ);
          endcase
        end
      end
      4: begin
        add_request(OP_WRITE, REG_LCR, {8'($urandom), 1'b1, 7'($urandom)});
        case ($urandom_range(0, 3))
          0: add_request(OP_WRITE, REG_IO, 16'($urandom));
          1: add_request(OP_WRITE, REG_IER, 16'($urandom));
          2: add_request(OP_READ, REG_IO);
          default: add_request(OP_READ, REG_IER);
        endcase
        add_request(OP_READ, REG_BAUD);
      end
      5: begin
        case ($urandom_range(0, 5))
          0: idx = REG_IER;
          1: idx = REG_LCR;
          2: idx = REG_MCR;
          3: idx = REG_SCRATCH;
          4: idx = REG_CNTL;
          default: idx = REG_BAUD;
        endcase
        add_request(OP_WRITE, idx, 16'($urandom));
        add_request(OP_READ, idx);
      end
      6: begin
        add_request(OP_WRITE, REG_IIR, 16'($urandom));
        add_request(OP_READ, REG_IIR);
        add_request(OP_READ, REG_IRQ);
      end
      7: begin
        wd = 16'($urandom);
        wd[0] = $urandom_range(0, 4) != 0;
        add_request(OP_WRITE, REG_ENABLES, wd);
        add_request(OP_READ, 4'($urandom_range(0, 15)));
      end
      8: begin
        case ($urandom_range(0, 4))
          0: idx = REG_IRQ;
          1: idx = REG_LSR;
          2: idx = REG_MSR;
          3: idx = REG_STAT;
          default: idx = 4'($urandom_range(REG_BAUD + 1, 15));
        endcase
        add_request(OP_WRITE, idx, 16'($urandom));
        add_request(OP_READ, idx);
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) add_request(OP_TX_DRAIN, 4'($urandom_range(0, 15)));
      end
    endcase
  endtask

  always @(posedge clk) begin
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (rst) begin
      reset_uart_model();
    end else if (s_axis_tvalid && s_axis_tready) begin
      expected_responses.push_back(predict_uart_response(req_t'(s_axis_tdata[$bits(req_t)-1:0])));
    end
  end

  always @(negedge clk) begin : request_driver
    logic v;
    uart_request_t item;
    v = s_axis_tvalid;
    if (rst) begin
      v = 1'b0;
    end else begin
      if (req_taken) v = 1'b0;
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_requests.size() != 0 &&
                     !(queued_requests[0].wait_idle && expected_responses.size() != 0)) begin
          item = queued_requests.pop_front();
          s_axis_tdata <= S_DATA_W'(item.req);
          v = 1'b1;
          gap_left = draw_wait(send_calm);
        end
      end
    end
    s_axis_tvalid <= v;
  end

  always @(posedge clk) begin : response_monitor
    rsp_t got;
    rsp_t want;
    rsp_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = rsp_t'(m_axis_tdata[$bits(rsp_t)-1:0]);
      if (expected_responses.size() == 0) begin
        $error("unexpected response: actual %h", got);
        mismatch_count++;
      end else begin
        want = expected_responses.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
          mismatch_count++;
        end
        if (got.tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %b, actual %b", want.tx_valid, got.tx_valid);
          mismatch_count++;
        end
        if (got.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, actual %h", want.tx_byte, got.tx_byte);
          mismatch_count++;
        end
        if (got.irq !== want.irq) begin
          $error("irq: expected %b, actual %b", want.irq, got.irq);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rsp_taken) stall_left = draw_wait(recv_calm);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    // disabled block: reads give 0, writes ignored, line side still works
    add_request(OP_READ, REG_STAT);
    add_request(OP_WRITE, REG_LCR, 16'h0080);
    add_request(OP_RX_BYTE, REG_IRQ, 16'h0000, 8'hff);
    add_request(OP_TX_DRAIN, REG_IRQ);
    add_request(OP_WRITE, REG_ENABLES, 16'hff01);
    add_request(OP_READ, REG_ENABLES);
    // divisor latch access through io and ier
    add_request(OP_WRITE, REG_LCR, 16'h0080);
    add_request(OP_WRITE, REG_IO, 16'hffff);
    add_request(OP_WRITE, REG_LCR, 16'h0080);
    add_request(OP_WRITE, REG_IER, 16'h00a5);
    add_request(OP_WRITE, REG_LCR, 16'h00ff);
    add_request(OP_READ, REG_IO);
    add_request(OP_READ, REG_IER);
    add_request(OP_READ, REG_BAUD);
    // fill rx past full for overrun
    for (int i = 0; i < FIFO_DEPTH; i++) add_request(OP_RX_BYTE, REG_IRQ, 16'h0000,
                                                     i[0] ? 8'h00 : 8'h5a);
    add_request(OP_READ, REG_STAT);
    add_request(OP_READ, REG_LSR);
    add_request(OP_READ, REG_LSR);
    add_request(OP_READ, REG_IO);
    add_request(OP_WRITE, REG_IIR, 16'h0006);
    add_request(OP_READ, REG_IO);
    add_request(OP_WRITE, REG_IER, 16'h0003);
    add_request(OP_READ, REG_IIR);
    add_request(OP_READ, REG_IRQ);
    add_request(OP_WRITE, REG_MSR, 16'hffff);
    add_request(OP_WRITE, REG_UNMAPPED, 16'hffff);
    add_request(OP_READ, REG_UNMAPPED);
    queued_requests[queued_requests.size()-1].wait_idle = 1'b1;
    while (queued_requests.size() < 840) begin
      add_random_sequence();
      if ($urandom_range(0, 24) == 0) queued_requests[queued_requests.size()-1].wait_idle = 1'b1;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (queued_requests.size() != 0 || s_axis_tvalid || expected_responses.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
